### design/mcif_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcif_pkg
// Shared types and constants of the multichannel IIR filter.
// ----------------------------------------------------------------------------
package mcif_pkg;

    localparam int DATA_W = 24;
    localparam int PAIR_W = 2 * DATA_W;
    localparam int PROD_W = 2 * DATA_W;
    localparam int CMD_W  = 2;
    localparam int CH_W   = 3;
    localparam int TAPF_W = 6;
    localparam int ACT_W  = 4;
    localparam int NTAP_W = 7;
    localparam int CIDX_W = 2;
    localparam int RSH    = 20;

    // Item commands
    localparam logic [CMD_W-1:0] CMD_SAMPLE = 2'd0;
    localparam logic [CMD_W-1:0] CMD_WR_FF  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_WR_FB  = 2'd2;

    // Register indexes
    localparam logic [CIDX_W-1:0] REG_ACTIVE = 2'd0;
    localparam logic [CIDX_W-1:0] REG_FF     = 2'd1;
    localparam logic [CIDX_W-1:0] REG_FB     = 2'd2;

    // Half-word write enables of a paired memory entry
    typedef struct packed {
        logic lo;
        logic hi;
    } t_wr_en;

    // Control of the multiply-accumulate unit
    typedef struct packed {
        logic valid;
        logic clear;
    } t_mac_ctl;

endpackage

### design/mcif_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcif_store
// Coefficient and history memories, one write and one registered read each.
// Low half: feedforward tap / input history. High half: feedback / output.
// ----------------------------------------------------------------------------
module mcif_store
    import mcif_pkg::*;
#(
    parameter int ADDR_W = 9,
    parameter int DEPTH  = 512
) (
    input  logic              i_clk,
    input  t_wr_en            i_coef_we,
    input  logic [ADDR_W-1:0] i_coef_waddr,
    input  logic [PAIR_W-1:0] i_coef_wdata,
    input  logic [ADDR_W-1:0] i_coef_raddr,
    output logic [PAIR_W-1:0] o_coef_rdata,
    input  t_wr_en            i_hist_we,
    input  logic [ADDR_W-1:0] i_hist_waddr,
    input  logic [PAIR_W-1:0] i_hist_wdata,
    input  logic [ADDR_W-1:0] i_hist_raddr,
    output logic [PAIR_W-1:0] o_hist_rdata
);

    logic [PAIR_W-1:0] r_coef_mem [DEPTH];
    logic [PAIR_W-1:0] r_hist_mem [DEPTH];

    // Write each half under its own enable
    always_ff @(posedge i_clk) begin
        if (i_coef_we.lo) begin
            r_coef_mem[i_coef_waddr][DATA_W-1:0] <= i_coef_wdata[DATA_W-1:0];
        end
        if (i_coef_we.hi) begin
            r_coef_mem[i_coef_waddr][PAIR_W-1:DATA_W] <= i_coef_wdata[PAIR_W-1:DATA_W];
        end
        if (i_hist_we.lo) begin
            r_hist_mem[i_hist_waddr][DATA_W-1:0] <= i_hist_wdata[DATA_W-1:0];
        end
        if (i_hist_we.hi) begin
            r_hist_mem[i_hist_waddr][PAIR_W-1:DATA_W] <= i_hist_wdata[PAIR_W-1:DATA_W];
        end
    end

    // Registered reads
    always_ff @(posedge i_clk) begin
        o_coef_rdata <= r_coef_mem[i_coef_raddr];
        o_hist_rdata <= r_hist_mem[i_hist_raddr];
    end

endmodule

### design/mcif_mac.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcif_mac
// Shared multiply-accumulate with rounding to Q1.23 and saturation.
// ----------------------------------------------------------------------------
module mcif_mac
    import mcif_pkg::*;
#(
    parameter int ACC_W = 56
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_mac_ctl                 i_ctl,
    input  logic signed [DATA_W-1:0] i_coef,
    input  logic signed [DATA_W-1:0] i_sample,
    output logic                     o_busy,
    output logic signed [DATA_W-1:0] o_y,
    output logic                     o_sat
);

    localparam int RND_W = ACC_W - RSH;

    logic                     r_prod_v;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [ACC_W-1:0]  r_acc;
    logic signed [ACC_W-1:0]  w_biased;
    logic signed [RND_W-1:0]  w_rnd;
    logic                     w_hi_ones;
    logic                     w_hi_zeros;

    // Multiply stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prod_v <= 1'b0;
        end else begin
            r_prod_v <= i_ctl.valid;
        end
        r_prod <= i_coef * i_sample;
    end

    // Accumulate stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.clear) begin
            r_acc <= '0;
        end else if (r_prod_v) begin
            r_acc <= r_acc + ACC_W'(r_prod);
        end
    end

    // Round half up, then clip to Q1.23
    assign w_biased   = r_acc + (ACC_W'(1) <<< (RSH - 1));
    assign w_rnd      = w_biased[ACC_W-1:RSH];
    assign w_hi_ones  = &w_rnd[RND_W-1:DATA_W-1];
    assign w_hi_zeros = ~|w_rnd[RND_W-1:DATA_W-1];
    assign o_sat      = !(w_hi_ones || w_hi_zeros);
    assign o_busy     = r_prod_v;

    always_comb begin
        if (!o_sat) begin
            o_y = w_rnd[DATA_W-1:0];
        end else if (w_rnd[RND_W-1]) begin
            o_y = {1'b1, {(DATA_W-1){1'b0}}};
        end else begin
            o_y = {1'b0, {(DATA_W-1){1'b1}}};
        end
    end

endmodule

### design/multichannel_iir_filter_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multichannel_iir_filter_top
// Multichannel direct-form-I IIR filter with coefficient and history memories.
// ----------------------------------------------------------------------------
// A sample item is taken and its input stored, one memory read per tap runs
// through the single shared multiply-accumulate, the read/multiply/add
// pipeline empties, and the result is rounded, written to the output history
// and loaded into the result register once that is free. A coefficient item
// or an ignored item is done as it is taken. After reset and after each write
// to the active, feedforward or feedback register the block clears all
// N_CHAN * MAX_TAPS entries of both memories, stalling the input meanwhile.
// The result register holds a finished sample while the next item is taken.
module multichannel_iir_filter_top
    import mcif_pkg::*;
#(
    parameter int N_CHAN   = 8,
    parameter int MAX_TAPS = 64
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  logic [CMD_W-1:0]         i_command,
    input  logic [CH_W-1:0]          i_channel,
    input  logic [TAPF_W-1:0]        i_tap_index,
    input  logic signed [DATA_W-1:0] i_data_value,
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output logic [CH_W-1:0]          o_out_channel,
    output logic signed [DATA_W-1:0] o_filtered_sample,
    output logic                     o_saturated,
    input  logic                     i_cfg_we,
    input  logic [CIDX_W-1:0]        i_cfg_index,
    input  logic [NTAP_W-1:0]        i_cfg_data
);

    localparam int DEPTH  = N_CHAN * MAX_TAPS;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int TAP_W  = $clog2(MAX_TAPS);
    localparam int CNT_W  = $clog2(MAX_TAPS + 1);
    localparam int ACC_W  = PROD_W + $clog2(2 * MAX_TAPS) + 1;

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_RUN   = 3'd2;
    localparam logic [2:0] ST_DRAIN = 3'd3;
    localparam logic [2:0] ST_FIN   = 3'd4;

    logic [2:0]        r_state, n_state;
    logic [ADDR_W-1:0] r_clr_addr, n_clr_addr;
    logic [ACT_W-1:0]  r_active, n_active;
    logic [CNT_W-1:0]  r_nff, n_nff;
    logic [CNT_W-1:0]  r_nfb, n_nfb;
    logic [TAP_W-1:0]  r_ipos, n_ipos;
    logic [TAP_W-1:0]  r_opos, n_opos;
    logic [TAP_W-1:0]  r_k, n_k;
    logic [TAP_W-1:0]  r_hidx, n_hidx;
    logic              r_phase, n_phase;
    logic              r_iss_v, n_iss_v;
    logic              r_iss_ph, n_iss_ph;
    logic [CH_W-1:0]   r_ch, n_ch;
    logic [ADDR_W-1:0] r_base, n_base;
    logic              r_out_valid, n_out_valid;
    logic [CH_W-1:0]   r_out_ch, n_out_ch;
    logic [DATA_W-1:0] r_out_y, n_out_y;
    logic              r_out_sat, n_out_sat;

    logic              w_accept;
    logic              w_ch_ok;
    logic [ADDR_W-1:0] w_in_base;
    logic [ADDR_W-1:0] w_in_addr;
    logic [CNT_W-1:0]  w_n_cur;
    logic              w_last_k;
    logic              w_out_free;
    logic [TAP_W-1:0]  w_opos_next;
    logic [ACT_W-1:0]  w_cfg_act;
    logic [CNT_W-1:0]  w_cfg_taps;

    t_wr_en            w_coef_we, w_hist_we;
    logic [ADDR_W-1:0] w_coef_waddr, w_hist_waddr;
    logic [PAIR_W-1:0] w_coef_wdata, w_hist_wdata;
    logic [ADDR_W-1:0] w_coef_raddr, w_hist_raddr;
    logic [PAIR_W-1:0] w_coef_rdata, w_hist_rdata;

    t_mac_ctl                 w_mac_ctl;
    logic signed [DATA_W-1:0] w_mac_coef, w_mac_smp;
    logic                     w_mac_busy;
    logic signed [DATA_W-1:0] w_mac_y;
    logic                     w_mac_sat;

    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_ch_ok    = ({1'b0, i_channel} < r_active)
                        && (32'(i_channel) < 32'(N_CHAN));
    assign w_in_base  = ADDR_W'(32'(i_channel) * MAX_TAPS);
    assign w_in_addr  = ADDR_W'(32'(i_channel) * MAX_TAPS + 32'(i_tap_index));
    assign w_n_cur    = r_phase ? r_nfb : r_nff;
    assign w_last_k   = (CNT_W'(r_k) == w_n_cur - CNT_W'(1));
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_opos_next = (CNT_W'(r_opos) + CNT_W'(1) == r_nfb) ? '0 : r_opos + TAP_W'(1);

    // Clamp register writes into range
    always_comb begin
        if (i_cfg_data[ACT_W-1:0] == '0) begin
            w_cfg_act = ACT_W'(1);
        end else if (32'(i_cfg_data[ACT_W-1:0]) > 32'(N_CHAN)) begin
            w_cfg_act = ACT_W'(N_CHAN);
        end else begin
            w_cfg_act = i_cfg_data[ACT_W-1:0];
        end
        if (i_cfg_data == '0) begin
            w_cfg_taps = CNT_W'(1);
        end else if (32'(i_cfg_data) > 32'(MAX_TAPS)) begin
            w_cfg_taps = CNT_W'(MAX_TAPS);
        end else begin
            w_cfg_taps = CNT_W'(i_cfg_data);
        end
    end

    // Sequencer
    always_comb begin
        n_state     = r_state;
        n_clr_addr  = r_clr_addr;
        n_active    = r_active;
        n_nff       = r_nff;
        n_nfb       = r_nfb;
        n_ipos      = r_ipos;
        n_opos      = r_opos;
        n_k         = r_k;
        n_hidx      = r_hidx;
        n_phase     = r_phase;
        n_iss_v     = 1'b0;
        n_iss_ph    = r_phase;
        n_ch        = r_ch;
        n_base      = r_base;
        n_out_valid = r_out_valid && i_out_stall;
        n_out_ch    = r_out_ch;
        n_out_y     = r_out_y;
        n_out_sat   = r_out_sat;
        w_coef_we    = '0;
        w_coef_waddr = w_in_addr;
        w_coef_wdata = {i_data_value, i_data_value};
        w_hist_we    = '0;
        w_hist_waddr = r_base + ADDR_W'(r_ipos);
        w_hist_wdata = {w_mac_y, i_data_value};
        w_mac_ctl    = '0;

        case (r_state)
            ST_CLEAR: begin
                // Zero one entry of both memories per cycle
                w_coef_we    = '{lo: 1'b1, hi: 1'b1};
                w_hist_we    = '{lo: 1'b1, hi: 1'b1};
                w_coef_waddr = r_clr_addr;
                w_hist_waddr = r_clr_addr;
                w_coef_wdata = '0;
                w_hist_wdata = '0;
                n_clr_addr   = r_clr_addr + ADDR_W'(1);
                if (32'(r_clr_addr) == DEPTH - 1) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (w_accept && w_ch_ok) begin
                    case (i_command)
                        CMD_WR_FF: begin
                            w_coef_we.lo = ({1'b0, i_tap_index} < NTAP_W'(r_nff));
                        end
                        CMD_WR_FB: begin
                            w_coef_we.hi = ({1'b0, i_tap_index} < NTAP_W'(r_nfb));
                        end
                        CMD_SAMPLE: begin
                            // Store the new input, then walk the taps
                            w_hist_we.lo  = 1'b1;
                            w_hist_waddr  = w_in_base + ADDR_W'(r_ipos);
                            w_mac_ctl.clear = 1'b1;
                            n_ch    = i_channel;
                            n_base  = w_in_base;
                            n_k     = '0;
                            n_hidx  = r_ipos;
                            n_phase = 1'b0;
                            n_state = ST_RUN;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_RUN: begin
                n_iss_v  = 1'b1;
                n_iss_ph = r_phase;
                n_k      = r_k + TAP_W'(1);
                n_hidx   = (r_hidx == '0) ? TAP_W'(w_n_cur - CNT_W'(1))
                                          : r_hidx - TAP_W'(1);
                if (w_last_k) begin
                    n_k = '0;
                    if (!r_phase) begin
                        n_phase = 1'b1;
                        n_hidx  = r_opos;
                    end else begin
                        n_state = ST_DRAIN;
                    end
                end
            end
            ST_DRAIN: begin
                if (!r_iss_v && !w_mac_busy) begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                // Deliver the result and close the item
                if (w_out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_ch     = r_ch;
                    n_out_y      = w_mac_y;
                    n_out_sat    = w_mac_sat;
                    w_hist_we.hi = 1'b1;
                    w_hist_waddr = r_base + ADDR_W'(w_opos_next);
                    if ({1'b0, r_ch} == r_active - ACT_W'(1)) begin
                        n_ipos = (CNT_W'(r_ipos) + CNT_W'(1) == r_nff) ? '0
                                 : r_ipos + TAP_W'(1);
                        n_opos = w_opos_next;
                    end
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        // Writes to the active, feedforward or feedback register restart the clearing sweep
        if (i_cfg_we && (i_cfg_index == REG_ACTIVE || i_cfg_index == REG_FF
                         || i_cfg_index == REG_FB)) begin
            case (i_cfg_index)
                REG_ACTIVE: n_active = w_cfg_act;
                REG_FF:     n_nff    = w_cfg_taps;
                REG_FB:     n_nfb    = w_cfg_taps;
                default: begin
                end
            endcase
            n_state    = ST_CLEAR;
            n_clr_addr = '0;
            n_ipos     = '0;
            n_opos     = '0;
        end

        w_mac_ctl.valid = r_iss_v;
    end

    assign w_coef_raddr = r_base + ADDR_W'(r_k);
    assign w_hist_raddr = r_base + ADDR_W'(r_hidx);
    assign w_mac_coef   = r_iss_ph ? w_coef_rdata[PAIR_W-1:DATA_W] : w_coef_rdata[DATA_W-1:0];
    assign w_mac_smp    = r_iss_ph ? w_hist_rdata[PAIR_W-1:DATA_W] : w_hist_rdata[DATA_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr_addr  <= '0;
            r_active    <= ACT_W'(1);
            r_nff       <= CNT_W'(1);
            r_nfb       <= CNT_W'(1);
            r_ipos      <= '0;
            r_opos      <= '0;
            r_k         <= '0;
            r_hidx      <= '0;
            r_phase     <= 1'b0;
            r_iss_v     <= 1'b0;
            r_iss_ph    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_addr  <= n_clr_addr;
            r_active    <= n_active;
            r_nff       <= n_nff;
            r_nfb       <= n_nfb;
            r_ipos      <= n_ipos;
            r_opos      <= n_opos;
            r_k         <= n_k;
            r_hidx      <= n_hidx;
            r_phase     <= n_phase;
            r_iss_v     <= n_iss_v;
            r_iss_ph    <= n_iss_ph;
            r_out_valid <= n_out_valid;
        end
        r_ch      <= n_ch;
        r_base    <= n_base;
        r_out_ch  <= n_out_ch;
        r_out_y   <= n_out_y;
        r_out_sat <= n_out_sat;
    end

    assign o_in_stall        = (r_state != ST_IDLE);
    assign o_out_valid       = r_out_valid;
    assign o_out_channel     = r_out_ch;
    assign o_filtered_sample = r_out_y;
    assign o_saturated       = r_out_sat;

    mcif_store #(
        .ADDR_W (ADDR_W),
        .DEPTH  (DEPTH)
    ) u_store (
        .i_clk        (i_clk),
        .i_coef_we    (w_coef_we),
        .i_coef_waddr (w_coef_waddr),
        .i_coef_wdata (w_coef_wdata),
        .i_coef_raddr (w_coef_raddr),
        .o_coef_rdata (w_coef_rdata),
        .i_hist_we    (w_hist_we),
        .i_hist_waddr (w_hist_waddr),
        .i_hist_wdata (w_hist_wdata),
        .i_hist_raddr (w_hist_raddr),
        .o_hist_rdata (w_hist_rdata)
    );

    mcif_mac #(
        .ACC_W (ACC_W)
    ) u_mac (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (w_mac_ctl),
        .i_coef   (w_mac_coef),
        .i_sample (w_mac_smp),
        .o_busy   (w_mac_busy),
        .o_y      (w_mac_y),
        .o_sat    (w_mac_sat)
    );

    // Positions stay inside their circular buffers
    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (CNT_W'(r_ipos) < r_nff) && (CNT_W'(r_opos) < r_nfb))
        else $error("history position beyond tap count");

    // A result is only taken from an emptied accumulator
    a_fin_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FIN) |-> (!w_mac_busy && !r_iss_v))
        else $error("result formed while pipeline busy");

    // Coefficients never change while a sample is being filtered
    a_no_coef_wr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RUN || r_state == ST_DRAIN) |-> !(w_coef_we.lo || w_coef_we.hi))
        else $error("coefficient write during filtering");

    // Reads are issued only while walking the taps
    a_issue_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_iss_v |-> $past(r_state) == ST_RUN)
        else $error("tap read outside tap walk");

endmodule

### tb/sv/multichannel_iir_filter_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multichannel_iir_filter_top_tb
// Self-checking bench for the multichannel IIR filter. A predictor with its
// own coefficient and history stores forecasts every filtered sample, and a
// checker compares each result item with the oldest forecast.
// ----------------------------------------------------------------------------
module multichannel_iir_filter_top_tb;
    import mcif_pkg::*;

    localparam int NCH   = 8;
    localparam int NTAPS = 64;
    localparam int DEPTH = NCH * NTAPS;
    // Codes that the package leaves unnamed
    localparam logic [CMD_W-1:0]  CMD_UNKNOWN = 2'd3;
    localparam logic [CIDX_W-1:0] REG_NONE    = 2'd3;
    localparam int SETTLE = 150;

    typedef struct {
        logic [CH_W-1:0]          chan;
        logic signed [DATA_W-1:0] sample;
        logic                     sat;
    } t_filtered;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     i_in_valid = 1'b0;
    logic                     o_in_stall;
    logic [CMD_W-1:0]         i_command = CMD_SAMPLE;
    logic [CH_W-1:0]          i_channel = '0;
    logic [TAPF_W-1:0]        i_tap_index = '0;
    logic signed [DATA_W-1:0] i_data_value = '0;
    logic                     o_out_valid;
    logic                     i_out_stall = 1'b0;
    logic [CH_W-1:0]          o_out_channel;
    logic signed [DATA_W-1:0] o_filtered_sample;
    logic                     o_saturated;
    logic                     i_cfg_we = 1'b0;
    logic [CIDX_W-1:0]        i_cfg_index = REG_ACTIVE;
    logic [NTAP_W-1:0]        i_cfg_data = '0;

    multichannel_iir_filter_top dut (.*);

    always #2 i_clk = ~i_clk;

    // Predictor state
    logic signed [DATA_W-1:0] ff_coef [DEPTH];
    logic signed [DATA_W-1:0] fb_coef [DEPTH];
    logic signed [DATA_W-1:0] in_hist [DEPTH];
    logic signed [DATA_W-1:0] out_hist [DEPTH];
    int unsigned in_pos, out_pos, n_act, n_ff, n_fb;
    t_filtered   pending[$];

    int  errors = 0;
    int  n_accepted = 0;
    int  n_checked = 0;
    int  n_saturated = 0;
    int  n_cfg = 0;
    bit  steady_in = 1'b0;
    bit  steady_out = 1'b0;

    function automatic int unsigned clamp_count(int unsigned v, int unsigned hi);
        if (v < 1) return 1;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic void clear_filter_state();
        for (int i = 0; i < DEPTH; i++) begin
            ff_coef[i] = '0;
            fb_coef[i] = '0;
            in_hist[i] = '0;
            out_hist[i] = '0;
        end
        in_pos = 0;
        out_pos = 0;
    endfunction

    function automatic void apply_register(logic [CIDX_W-1:0] idx, logic [NTAP_W-1:0] val);
        case (idx)
            REG_ACTIVE: n_act = clamp_count(val[3:0], NCH);
            REG_FF:     n_ff = clamp_count(val, NTAPS);
            REG_FB:     n_fb = clamp_count(val, NTAPS);
            default:    return;
        endcase
        clear_filter_state();
    endfunction

    // Work out the effect of one accepted item and queue its result if any
    function automatic void filter_item(logic [CMD_W-1:0] cmd, logic [CH_W-1:0] ch,
                                        logic [TAPF_W-1:0] tap,
                                        logic signed [DATA_W-1:0] val);
        int unsigned base;
        longint      acc;
        longint      rnd;
        t_filtered   r;
        if (ch >= n_act) return;
        base = ch * NTAPS;
        case (cmd)
            CMD_WR_FF: begin
                if (tap < n_ff) ff_coef[base + tap] = val;
                return;
            end
            CMD_WR_FB: begin
                if (tap < n_fb) fb_coef[base + tap] = val;
                return;
            end
            CMD_SAMPLE: ;
            default: return;
        endcase
        in_hist[base + (in_pos % n_ff)] = val;
        acc = 0;
        for (int unsigned k = 0; k < n_ff; k++)
            acc += longint'(ff_coef[base + k]) *
                   longint'(in_hist[base + (in_pos + n_ff - k) % n_ff]);
        for (int unsigned k = 0; k < n_fb; k++)
            acc += longint'(fb_coef[base + k]) *
                   longint'(out_hist[base + (out_pos + n_fb - k) % n_fb]);
        rnd = (acc + (64'sd1 <<< 19)) >>> RSH;
        r.chan = ch;
        r.sat = 1'b1;
        if (rnd > 64'sd8388607) r.sample = 24'sh7FFFFF;
        else if (rnd < -64'sd8388608) r.sample = 24'sh800000;
        else begin
            r.sample = rnd[DATA_W-1:0];
            r.sat = 1'b0;
        end
        out_hist[base + (out_pos + 1) % n_fb] = r.sample;
        if (ch == n_act - 1) begin
            in_pos = (in_pos + 1) % n_ff;
            out_pos = (out_pos + 1) % n_fb;
        end
        pending.push_back(r);
    endfunction

    // Mostly short gaps, now and then a long one
    function automatic int idle_cycles();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Present one item at a falling edge and hold it until taken
    task automatic send_item(logic [CMD_W-1:0] cmd, logic [CH_W-1:0] ch,
                             logic [TAPF_W-1:0] tap, logic signed [DATA_W-1:0] val);
        int gap;
        i_in_valid <= 1'b1;
        i_command <= cmd;
        i_channel <= ch;
        i_tap_index <= tap;
        i_data_value <= val;
        do @(posedge i_clk); while (o_in_stall);
        filter_item(cmd, ch, tap, val);
        n_accepted++;
        @(negedge i_clk);
        gap = steady_in ? 0 : idle_cycles();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
    endtask

    // Drop valid and wait until every forecast result has come out
    task automatic drain();
        i_in_valid <= 1'b0;
        wait (pending.size() == 0);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    task automatic write_register(logic [CIDX_W-1:0] idx, logic [NTAP_W-1:0] val);
        drain();
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        apply_register(idx, val);
        n_cfg++;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Output stall: random bursts, calm stretches when steady_out is set
    initial begin
        forever begin
            @(negedge i_clk);
            if (steady_out) i_out_stall <= 1'b0;
            else if ($urandom_range(0, 99) < 25) begin
                i_out_stall <= 1'b1;
                repeat (idle_cycles()) @(negedge i_clk);
                @(negedge i_clk);
                i_out_stall <= 1'b0;
            end else i_out_stall <= 1'b0;
        end
    end

    // Compare each result item with the oldest forecast
    always @(posedge i_clk) begin
        t_filtered e;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending.size() == 0) begin
                $display("%0t: unexpected result ch=%0d y=%0d sat=%0b", $time,
                         o_out_channel, o_filtered_sample, o_saturated);
                errors++;
            end else begin
                e = pending.pop_front();
                n_checked++;
                if (e.sat) n_saturated++;
                if (o_out_channel !== e.chan) begin
                    $display("%0t: channel expected %0d actual %0d", $time,
                             e.chan, o_out_channel);
                    errors++;
                end
                if (o_filtered_sample !== e.sample) begin
                    $display("%0t: sample expected %0d actual %0d", $time,
                             e.sample, o_filtered_sample);
                    errors++;
                end
                if (o_saturated !== e.sat) begin
                    $display("%0t: saturated expected %0b actual %0b", $time,
                             e.sat, o_saturated);
                    errors++;
                end
            end
        end
    end

    // Reset defaults, coefficient writes, ignored items, rounding and clipping
    task automatic test_single_channel();
        send_item(CMD_SAMPLE, 3'd0, 6'd0, 24'sd123);
        send_item(CMD_WR_FF, 3'd0, 6'd0, 24'sh100000);
        send_item(CMD_SAMPLE, 3'd0, 6'h3F, 24'sh7FFFFF);
        send_item(CMD_SAMPLE, 3'd0, 6'd0, 24'sh800000);
        send_item(CMD_WR_FF, 3'd0, 6'd1, 24'sh7FFFFF);
        send_item(CMD_WR_FF, 3'd1, 6'd0, 24'sh7FFFFF);
        send_item(CMD_UNKNOWN, 3'd0, 6'd0, 24'sd55);
        send_item(CMD_SAMPLE, 3'd5, 6'd0, 24'sd77);
        send_item(CMD_WR_FB, 3'd0, 6'd0, 24'sh7FFFFF);
        send_item(CMD_SAMPLE, 3'd0, 6'd0, 24'sd0);
        send_item(CMD_WR_FB, 3'd0, 6'd0, 24'sd0);
        send_item(CMD_WR_FF, 3'd0, 6'd0, 24'sh800000);
        send_item(CMD_SAMPLE, 3'd0, 6'd0, 24'sh7FFFFF);
        send_item(CMD_SAMPLE, 3'd0, 6'd0, 24'sh800000);
        // ties round upwards
        send_item(CMD_WR_FF, 3'd0, 6'd0, 24'sd1);
        send_item(CMD_SAMPLE, 3'd0, 6'd0, 24'sd524288);
        send_item(CMD_SAMPLE, 3'd0, 6'd0, -24'sd524288);
        send_item(CMD_SAMPLE, 3'd0, 6'd0, 24'sd1572864);
        send_item(CMD_SAMPLE, 3'd0, 6'd0, -24'sd1572864);
        write_register(REG_NONE, 7'h55);
        send_item(CMD_SAMPLE, 3'd0, 6'd0, 24'sd2097152);
    endtask

    // Clamped register values and the widest setting
    task automatic test_register_extremes();
        write_register(REG_ACTIVE, 7'd0);
        write_register(REG_FF, 7'd0);
        write_register(REG_FB, 7'd0);
        send_item(CMD_SAMPLE, 3'd0, 6'd0, 24'sd9);
        write_register(REG_ACTIVE, 7'd15);
        write_register(REG_FF, 7'd127);
        write_register(REG_FB, 7'd65);
        for (int c = 0; c < NCH; c++)
            send_item(CMD_WR_FF, 3'(c), 6'd63, 24'sh080000);
        send_item(CMD_WR_FB, 3'd7, 6'd63, 24'sh040000);
        for (int c = 0; c < NCH; c++)
            send_item(CMD_SAMPLE, 3'(c), 6'd0, 24'sh400000);
    endtask

    function automatic logic signed [DATA_W-1:0] coef_value(int unsigned ntaps);
        int lim;
        if ($urandom_range(0, 99) < 15) return DATA_W'($urandom);
        lim = (1 << 20) / ntaps;
        return DATA_W'($urandom_range(0, 2 * lim)) - DATA_W'(lim);
    endfunction

    // Phases of fixed and random settings with frame-ordered traffic and some noise
    task automatic test_random_traffic(int items);
        int unsigned next_ch;
        int          r;
        for (int phase = 0; phase < 8; phase++) begin
            case (phase)
                0: begin
                    write_register(REG_ACTIVE, 7'd8);
                    write_register(REG_FF, 7'd64);
                    write_register(REG_FB, 7'd64);
                end
                1: begin
                    write_register(REG_ACTIVE, 7'd1);
                    write_register(REG_FF, 7'd1);
                    write_register(REG_FB, 7'd1);
                end
                default: begin
                    write_register(REG_ACTIVE, NTAP_W'($urandom));
                    write_register(REG_FF, NTAP_W'($urandom_range(1, 12)));
                    write_register(REG_FB, NTAP_W'($urandom_range(1, 12)));
                end
            endcase
            steady_in = (phase % 3 == 2);
            steady_out = (phase % 4 == 3);
            next_ch = 0;
            for (int i = 0; i < items / 8; i++) begin
                r = $urandom_range(0, 99);
                if (r < 20)
                    send_item(($urandom_range(0, 1) != 0) ? CMD_WR_FF : CMD_WR_FB,
                              3'($urandom_range(0, n_act - 1)),
                              6'($urandom_range(0, NTAPS - 1) % n_ff),
                              coef_value(n_ff + n_fb));
                else if (r < 88) begin
                    // mostly the next channel of the frame, now and then a stray one
                    if ($urandom_range(0, 19) == 0)
                        next_ch = $urandom_range(0, n_act - 1);
                    send_item(CMD_SAMPLE, 3'(next_ch), TAPF_W'($urandom),
                              DATA_W'($urandom));
                    next_ch = (next_ch + 1) % n_act;
                end else
                    send_item(CMD_W'($urandom), CH_W'($urandom), TAPF_W'($urandom),
                              DATA_W'($urandom));
            end
        end
        steady_in = 1'b0;
        steady_out = 1'b0;
    endtask

    initial begin
        n_act = 1;
        n_ff = 1;
        n_fb = 1;
        clear_filter_state();
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_single_channel();
        test_register_extremes();
        test_random_traffic(1800);
        drain();
        $display("Run covered %0d items, %0d register writes, %0d results checked",
                 n_accepted, n_cfg, n_checked);
        $display("Clipped results among them: %0d; mismatches: %0d", n_saturated, errors);
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // Overall time limit
    initial begin
        #20_000_000;
        $display("Timed out with %0d results outstanding", pending.size());
        $display("== FAIL ==");
        $finish;
    end

endmodule

### multichannel_iir_filter_top.f
design/mcif_pkg.sv
design/mcif_store.sv
design/mcif_mac.sv
design/multichannel_iir_filter_top.sv
tb/sv/multichannel_iir_filter_top_tb.sv
